>>> rtl/core/popa_pkg.sv
// Package for the paged object pool allocator: field widths, status codes,
// object state codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package popa_pkg;

   // Stream payload layout.
   localparam int PAGE_FIELD_W  = 4;
   localparam int SLOT_FIELD_W  = 4;
   localparam int COUNT_FIELD_W = 9;
   localparam int PAGES_FIELD_W = 5;
   localparam int TOTAL_W       = 32;

   localparam int REQ_DATA_W = PAGE_FIELD_W + SLOT_FIELD_W;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = PAGE_FIELD_W + SLOT_FIELD_W + 3 * COUNT_FIELD_W
                               + PAGES_FIELD_W + 2 * TOTAL_W;
   localparam int RSP_USER_W = 2;

   // Bit offsets of the response fields inside rsp_tdata.
   localparam int RSP_IN_USE_LSB = PAGE_FIELD_W + SLOT_FIELD_W;
   localparam int RSP_PEAK_LSB   = RSP_IN_USE_LSB + 2 * COUNT_FIELD_W + PAGES_FIELD_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   typedef logic [RSP_USER_W-1:0] status_type;
   localparam status_type STATUS_OK            = 2'd0;
   localparam status_type STATUS_NO_MEMORY     = 2'd1;
   localparam status_type STATUS_MULTIPLE_FREE = 2'd2;
   localparam status_type STATUS_BAD_ADDRESS   = 2'd3;

   typedef logic [1:0] obj_state_type;
   localparam obj_state_type OBJ_NONE = 2'd0;
   localparam obj_state_type OBJ_FREE = 2'd1;
   localparam obj_state_type OBJ_USED = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_OBJECTS_PER_PAGE = 2'd0;
   localparam csr_index_type REG_MAX_PAGES        = 2'd1;

   localparam logic [CSR_DATA_W-1:0] OBJECTS_PER_PAGE_RESET = 5'd16;
   localparam logic [CSR_DATA_W-1:0] MAX_PAGES_RESET        = 5'd0;

endpackage

>>> rtl/core/paged_object_pool_allocator.sv
// Top level of the paged object pool allocator: control sequencer, counters
// and result register. Uses popa_pkg and two popa_ram instances.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one operation per item: tuser selects allocate or
// free, tdata names the page and slot to free. Every item gives exactly one
// item on the rsp channel with a status code in tuser and the granted object
// plus pool statistics in tdata.
// The csr channel writes objects_per_page (index 0) and max_pages (index 1);
// it is always ready and should only be used while no item is in flight.
// Sequence: an item is read from the stack and status memories in the cycle
// it is accepted and completes in S_EXEC once the output register is free,
// which then holds its result. A new item is taken only after the last one
// has completed. An allocate that finds the free stack empty builds a new
// page, walking all SLOTS_MAX slots of that page through the status memory
// one per cycle; the last slot waits for the output register to free up.
// Reset clears the counters and the page count. No memory clearing pass is
// run: a status entry counts only once its page has been built.
// When the receiver stalls, the result stays in the output register, the
// next item is still accepted, and it waits for the register to free up
// before it completes.
module paged_object_pool_allocator #(
   parameter int PAGE_LIMIT = 16,
   parameter int SLOTS_MAX  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [3:0] free_page, [7:4] free_slot
   input  logic [popa_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] func
   input  logic [popa_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [3:0] granted_page, [7:4] granted_slot, [16:8] in_use_count,
   // [25:17] free_count, [30:26] pages_in_use, [39:31] peak_in_use,
   // [71:40] allocation_total, [103:72] release_total
   output logic [popa_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [popa_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [popa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [popa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import popa_pkg::*;

   localparam int PW   = (PAGE_LIMIT > 1) ? $clog2(PAGE_LIMIT) : 1;
   localparam int SW   = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
   localparam int POOL = PAGE_LIMIT * SLOTS_MAX;
   localparam int SAW  = (POOL > 1) ? $clog2(POOL) : 1;
   localparam int MAW  = PW + SW;
   localparam int MDEPTH = 1 << MAW;
   localparam int CW   = $clog2(POOL + 1);
   localparam int PCW  = $clog2(PAGE_LIMIT + 1);
   localparam int SCW  = $clog2(SLOTS_MAX + 1);
   localparam int LMW  = CSR_DATA_W + SCW;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_FILL = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic                    func_ff, func_in;
   logic [PAGE_FIELD_W-1:0] page_ff, page_in;
   logic [SLOT_FIELD_W-1:0] slot_ff, slot_in;
   logic [SW-1:0]           fill_ff, fill_in;
   logic [CSR_DATA_W-1:0]   opp_ff, opp_in;
   logic [CSR_DATA_W-1:0]   maxp_ff, maxp_in;
   logic [CW-1:0]           free_top_ff, free_top_in;
   logic [PCW-1:0]          page_count_ff, page_count_in;
   logic [CW-1:0]           in_use_ff, in_use_in;
   logic [CW-1:0]           peak_ff, peak_in;
   logic [TOTAL_W-1:0]      alloc_ff, alloc_in;
   logic [TOTAL_W-1:0]      release_ff, release_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   status_type              rsp_tuser_ff, rsp_tuser_in;

   logic                    req_fire;
   logic                    out_free;
   logic [SCW-1:0]          slots_eff;
   logic [SCW-1:0]          last_slot;
   logic [LMW-1:0]          limit;
   logic                    stack_empty;
   logic                    no_memory;
   logic                    free_in_range;
   logic                    page_built;
   logic                    fill_last;
   logic [PW-1:0]           build_page;

   logic                    stack_we;
   logic [SAW-1:0]          stack_waddr;
   logic [MAW-1:0]          stack_wdata;
   logic [SAW-1:0]          stack_raddr;
   logic [MAW-1:0]          stack_rd;
   logic                    stat_we;
   logic [MAW-1:0]          stat_waddr;
   obj_state_type           stat_wdata;
   logic [MAW-1:0]          stat_raddr;
   obj_state_type           stat_rd;

   logic                    rsp_load;
   status_type              rsp_status;
   logic                    grant;
   logic [PW-1:0]           gpage;
   logic [SW-1:0]           gslot;

   // Free stack holds {page, slot} of each free object.
   popa_ram #(.WIDTH(MAW), .DEPTH(POOL)) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_en   (req_fire),
      .rd_addr (stack_raddr),
      .rd_data (stack_rd)
   );

   // Object status, addressed by {page, slot}.
   popa_ram #(.WIDTH(2), .DEPTH(MDEPTH)) u_status (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (stat_waddr),
      .wr_data (stat_wdata),
      .rd_en   (req_fire),
      .rd_addr (stat_raddr),
      .rd_data (stat_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign stack_raddr = SAW'(free_top_ff - CW'(1));
   assign stat_raddr  = {PW'(req_tdata[PAGE_FIELD_W-1:0]),
                         SW'(req_tdata[PAGE_FIELD_W +: SLOT_FIELD_W])};

   always_comb begin
      if (opp_ff == '0) begin
         slots_eff = SCW'(1);
      end else if (32'(opp_ff) > SLOTS_MAX) begin
         slots_eff = SCW'(SLOTS_MAX);
      end else begin
         slots_eff = SCW'(opp_ff);
      end
   end

   assign last_slot   = slots_eff - SCW'(1);
   assign limit       = LMW'(maxp_ff) * LMW'(slots_eff);
   assign stack_empty = (free_top_ff == '0);
   assign no_memory   = ((maxp_ff != '0) && (32'(in_use_ff) >= 32'(limit)))
                        || (stack_empty && (32'(page_count_ff) >= PAGE_LIMIT));
   assign free_in_range = (32'(page_ff) < PAGE_LIMIT) && (32'(slot_ff) < SLOTS_MAX);
   assign page_built    = (32'(page_ff) < 32'(page_count_ff));
   assign fill_last     = (fill_ff == SW'(SLOTS_MAX - 1));
   assign build_page    = PW'(page_count_ff);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      page_in       = page_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      opp_in        = opp_ff;
      maxp_in       = maxp_ff;
      free_top_in   = free_top_ff;
      page_count_in = page_count_ff;
      in_use_in     = in_use_ff;
      peak_in       = peak_ff;
      alloc_in      = alloc_ff;
      release_in    = release_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      stack_we      = 1'b0;
      stack_waddr   = '0;
      stack_wdata   = '0;
      stat_we       = 1'b0;
      stat_waddr    = '0;
      stat_wdata    = OBJ_NONE;
      rsp_load      = 1'b0;
      rsp_status    = STATUS_OK;
      grant         = 1'b0;
      gpage         = '0;
      gslot         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in  = req_tuser[0];
               page_in  = req_tdata[PAGE_FIELD_W-1:0];
               slot_in  = req_tdata[PAGE_FIELD_W +: SLOT_FIELD_W];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               rsp_load = 1'b1;
               if (func_ff == FUNC_ALLOC) begin
                  if (no_memory) begin
                     rsp_status = STATUS_NO_MEMORY;
                  end else if (stack_empty) begin
                     rsp_load = 1'b0;
                     state_in = S_FILL;
                     fill_in  = '0;
                  end else begin
                     free_top_in = free_top_ff - CW'(1);
                     stat_we     = 1'b1;
                     stat_waddr  = stack_rd;
                     stat_wdata  = OBJ_USED;
                     grant       = 1'b1;
                     gpage       = stack_rd[SW +: PW];
                     gslot       = stack_rd[SW-1:0];
                  end
               end else begin
                  // An object on a page not yet built has never been provisioned.
                  if (!free_in_range || !page_built) begin
                     rsp_status = STATUS_BAD_ADDRESS;
                  end else if (stat_rd == OBJ_FREE) begin
                     rsp_status = STATUS_MULTIPLE_FREE;
                  end else if (stat_rd != OBJ_USED) begin
                     rsp_status = STATUS_BAD_ADDRESS;
                  end else begin
                     stack_we    = 1'b1;
                     stack_waddr = SAW'(free_top_ff);
                     stack_wdata = {PW'(page_ff), SW'(slot_ff)};
                     stat_we     = 1'b1;
                     stat_waddr  = {PW'(page_ff), SW'(slot_ff)};
                     stat_wdata  = OBJ_FREE;
                     free_top_in = free_top_ff + CW'(1);
                     if (in_use_ff != '0) begin
                        in_use_in = in_use_ff - CW'(1);
                     end
                     release_in = release_ff + TOTAL_W'(1);
                  end
               end
            end
         end
         S_FILL: begin
            // Every slot of the new page is written so that stale status from
            // before reset never shows. The last slot within objects_per_page is
            // handed out at once, so it is marked used and never pushed.
            if (!fill_last || out_free) begin
               stat_we    = 1'b1;
               stat_waddr = {build_page, fill_ff};
               if (32'(fill_ff) < 32'(last_slot)) begin
                  stat_wdata  = OBJ_FREE;
                  stack_we    = 1'b1;
                  stack_waddr = SAW'(fill_ff);
                  stack_wdata = {build_page, fill_ff};
               end else if (32'(fill_ff) == 32'(last_slot)) begin
                  stat_wdata = OBJ_USED;
               end else begin
                  stat_wdata = OBJ_NONE;
               end
               if (fill_last) begin
                  free_top_in   = CW'(last_slot);
                  page_count_in = page_count_ff + PCW'(1);
                  grant         = 1'b1;
                  gpage         = build_page;
                  gslot         = SW'(last_slot);
                  rsp_load      = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  fill_in = fill_ff + SW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (grant) begin
         in_use_in = in_use_ff + CW'(1);
         if (in_use_in > peak_ff) begin
            peak_in = in_use_in;
         end
         alloc_in = alloc_ff + TOTAL_W'(1);
      end

      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tuser_in  = rsp_status;
         rsp_tdata_in  = {release_in,
                          alloc_in,
                          COUNT_FIELD_W'(peak_in),
                          PAGES_FIELD_W'(page_count_in),
                          COUNT_FIELD_W'(free_top_in),
                          COUNT_FIELD_W'(in_use_in),
                          SLOT_FIELD_W'(gslot),
                          PAGE_FIELD_W'(gpage)};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            REG_OBJECTS_PER_PAGE: opp_in  = csr_wdata;
            REG_MAX_PAGES:        maxp_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         opp_ff        <= OBJECTS_PER_PAGE_RESET;
         maxp_ff       <= MAX_PAGES_RESET;
         free_top_ff   <= '0;
         page_count_ff <= '0;
         in_use_ff     <= '0;
         peak_ff       <= '0;
         alloc_ff      <= '0;
         release_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         opp_ff        <= opp_in;
         maxp_ff       <= maxp_in;
         free_top_ff   <= free_top_in;
         page_count_ff <= page_count_in;
         in_use_ff     <= in_use_in;
         peak_ff       <= peak_in;
         alloc_ff      <= alloc_in;
         release_ff    <= release_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      page_ff      <= page_in;
      slot_ff      <= slot_in;
      fill_ff      <= fill_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

>>> rtl/core/popa_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read, taken while rd_en is high. No dependencies.
`timescale 1ns / 1ps

module popa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/popa_checker.sv
// Port-level assertions for the paged object pool allocator, bound to the
// top level. Uses popa_pkg.
`timescale 1ns / 1ps

module popa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [popa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [popa_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import popa_pkg::*;

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // One item at a time: the input side closes right after an accept.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in flight");

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only a successful allocate names an object.
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK)
      |-> rsp_tdata[PAGE_FIELD_W + SLOT_FIELD_W - 1:0] == '0)
      else $error("object granted on a failed item");

   // The high-water mark never falls below the current count.
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_PEAK_LSB +: COUNT_FIELD_W]
                     >= rsp_tdata[RSP_IN_USE_LSB +: COUNT_FIELD_W])
      else $error("peak below in-use count");

endmodule

bind paged_object_pool_allocator popa_checker u_popa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
